[hw/rtl/assert_macros.svh]
// assert_macros.svh: assertion macros shared by the RTL files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// concurrent assertion clocked on clk, disabled in reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`endif

[hw/rtl/pqa_pkg.sv]
// pqa_pkg: types, codes and constants of the aging priority queue.
// No dependencies.
package pqa_pkg;
    localparam int CAPACITY_DEF = 16;
    localparam logic [3:0] AGED_PRI_RST = 4'd2;
    localparam logic [3:0] AGE_FACTOR_RST = 4'd6;

    localparam logic [2:0] CMD_SORTED = 3'd0;
    localparam logic [2:0] CMD_FRONT  = 3'd1;
    localparam logic [2:0] CMD_BACK   = 3'd2;
    localparam logic [2:0] CMD_DETACH = 3'd3;
    localparam logic [2:0] CMD_REMOVE = 3'd4;
    localparam logic [2:0] CMD_AGE    = 3'd5;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NONE  = 2'd2;

    localparam logic CFG_AGED_PRI = 1'b0;
    localparam logic CFG_AGE_FACTOR = 1'b1;

    typedef struct packed {
        logic [15:0] id;
        logic [3:0]  pri;
        logic [31:0] created;
        logic [15:0] quantum;
    } entry_t;

    typedef struct packed {
        logic [2:0]  cmd;
        entry_t      ent;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        entry_t      ent;
        logic [4:0]  occupancy;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request, start
        logic do_insert;  // insert at computed position
        logic do_detach;  // remove at computed position
        logic age_step;   // examine one entry of the age scan
        logic set_rsp;    // capture result
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
    } dp_stat_t;
endpackage

[hw/rtl/pqa_if.sv]
// pqa_if: valid/ready channel interfaces for request, result and config.
// Depends on pqa_pkg.
interface pqa_req_if import pqa_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

interface pqa_rsp_if import pqa_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);
endinterface

interface pqa_cfg_if ();
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [3:0] wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
    modport monitor (input valid, input index, input wdata, input ready);
endinterface

[hw/rtl/pqa_ctrl.sv]
// pqa_ctrl: sequencer for one request at a time.
// Depends on pqa_pkg.
module pqa_ctrl import pqa_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  logic [2:0] req_cmd,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output dp_cmd_t  dp_cmd,
    input  dp_stat_t dp_stat
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_AGE  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [2:0] cmd_reg;
    logic rsp_valid_reg, rsp_valid_next;

    // accept a new request only once the previous result has drained
    assign req_ready = (state_reg == S_IDLE) && !rsp_valid_reg;
    assign rsp_valid = rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            cmd_reg <= CMD_SORTED;
        end
        else
        begin
            state_reg <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            if (req_valid && req_ready)
                cmd_reg <= req_cmd;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        dp_cmd = '0;
        dp_cmd.load = req_valid && req_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid && req_ready)
                    state_next = (req_cmd == CMD_AGE) ? S_AGE : S_EXEC;
            end
            S_EXEC:
            begin
                dp_cmd.do_insert = (cmd_reg == CMD_SORTED) || (cmd_reg == CMD_FRONT)
                                   || (cmd_reg == CMD_BACK);
                dp_cmd.do_detach = (cmd_reg == CMD_DETACH) || (cmd_reg == CMD_REMOVE);
                dp_cmd.set_rsp = 1'b1;
                rsp_valid_next = 1'b1;
                state_next = S_IDLE;
            end
            S_AGE:
            begin
                if (dp_stat.scan_done)
                begin
                    dp_cmd.set_rsp = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    dp_cmd.age_step = 1'b1;
            end
            default: state_next = S_IDLE;
        endcase
    end

    `include "assert_macros.svh"
    `ASSERT_CLK(a_no_accept_busy, (state_reg != S_IDLE) |-> !req_ready, "accept while busy")
    `ASSERT_CLK(a_rsp_after_work, $rose(rsp_valid_reg) |-> $past(state_reg) != S_IDLE, "stray result")
    `ASSERT_CLK(a_rsp_holds, (rsp_valid_reg && !rsp_ready) |=> rsp_valid_reg, "result dropped")
endmodule

[hw/rtl/pqa_dp.sv]
// pqa_dp: entry storage, shift network, search and aging compare.
// Depends on pqa_pkg.
module pqa_dp import pqa_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  dp_cmd_t  dp_cmd,
    output dp_stat_t dp_stat,
    input  req_t     req,
    input  logic     cfg_we,
    input  logic [0:0] cfg_index,
    input  logic [3:0] cfg_wdata,
    output rsp_t     rsp
);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    entry_t slot_reg [CAPACITY];
    logic [CW-1:0] used_reg;
    logic [3:0] aged_pri_reg, age_factor_reg;
    req_t req_reg;
    rsp_t rsp_reg;
    logic [CW-1:0] scan_left_reg;   // entries still to examine
    logic [CW-1:0] scan_pos_reg;

    // position search, independent per slot
    logic [CAPACITY-1:0] lower_mask, match_mask;
    logic [CW-1:0] ins_pos, det_pos;
    logic det_found;

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            lower_mask[i] = (CW'(i) < used_reg) && (slot_reg[i].pri < req_reg.ent.pri);
            match_mask[i] = (CW'(i) < used_reg) && (slot_reg[i].id == req_reg.ent.id);
        end
    end

    // sorted order: count of leading lower entries equals the first not-lower index
    always_comb
    begin
        ins_pos = used_reg;
        for (int i = CAPACITY - 1; i >= 0; i--)
            if ((CW'(i) < used_reg) && !lower_mask[i])
                ins_pos = CW'(i);
        if (req_reg.cmd == CMD_FRONT)
            ins_pos = '0;
        else if (req_reg.cmd == CMD_BACK)
            ins_pos = used_reg;
    end

    always_comb
    begin
        det_pos = '0;
        det_found = 1'b0;
        if (req_reg.cmd == CMD_REMOVE)
        begin
            det_found = (used_reg != '0);
            det_pos = used_reg - CW'(1);
        end
        else
        begin
            for (int i = CAPACITY - 1; i >= 0; i--)
                if (match_mask[i])
                begin
                    det_found = 1'b1;
                    det_pos = CW'(i);
                end
        end
    end

    // aging compare on the entry at scan position
    entry_t cur;
    logic [31:0] elapsed;
    logic [19:0] limit;
    logic starve;
    assign cur = slot_reg[scan_pos_reg[IW-1:0]];
    assign elapsed = req_reg.now - cur.created;
    assign limit = 20'(cur.quantum) * 20'(age_factor_reg);
    assign starve = (elapsed >= {12'd0, limit}) && (cur.pri != aged_pri_reg);

    assign dp_stat.scan_done = (scan_left_reg == '0);
    assign rsp = rsp_reg;

    logic full;
    assign full = (used_reg >= CW'(CAPACITY));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            aged_pri_reg <= AGED_PRI_RST;
            age_factor_reg <= AGE_FACTOR_RST;
            scan_left_reg <= '0;
            scan_pos_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_AGED_PRI)
                    aged_pri_reg <= cfg_wdata;
                else
                    age_factor_reg <= cfg_wdata;
            end
            if (dp_cmd.load)
            begin
                scan_left_reg <= used_reg;
                scan_pos_reg <= '0;
            end
            if (dp_cmd.do_insert && !full)
                used_reg <= used_reg + CW'(1);
            if (dp_cmd.do_detach && det_found)
                used_reg <= used_reg - CW'(1);
            if (dp_cmd.age_step)
            begin
                scan_left_reg <= scan_left_reg - CW'(1);
                if (!starve)
                    scan_pos_reg <= scan_pos_reg + CW'(1);
            end
        end
    end

    // payload: request capture, storage shifts, result
    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
            req_reg <= req;
        if (dp_cmd.do_insert && !full)
        begin
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (CW'(i) == ins_pos)
                    slot_reg[i] <= req_reg.ent;
                else if ((CW'(i) > ins_pos) && (i > 0))
                    slot_reg[i] <= slot_reg[(i > 0) ? i - 1 : 0];
            end
        end
        if (dp_cmd.do_detach && det_found)
        begin
            for (int i = 0; i < CAPACITY - 1; i++)
                if (CW'(i) >= det_pos)
                    slot_reg[i] <= slot_reg[i + 1];
        end
        if (dp_cmd.age_step && starve)
        begin
            // rotate the starved entry to the last held slot
            for (int i = 0; i < CAPACITY; i++)
            begin
                if (CW'(i) == used_reg - CW'(1))
                    slot_reg[i] <= '{id: cur.id, pri: aged_pri_reg,
                                      created: cur.created, quantum: cur.quantum};
                else if ((CW'(i) >= scan_pos_reg) && (i < CAPACITY - 1))
                    slot_reg[i] <= slot_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
        if (dp_cmd.set_rsp)
        begin
            rsp_reg.ent <= '0;
            rsp_reg.status <= ST_DONE;
            rsp_reg.occupancy <= 5'(used_reg);
            if (dp_cmd.do_insert)
            begin
                if (full)
                    rsp_reg.status <= ST_FULL;
                else
                    rsp_reg.occupancy <= 5'(used_reg + CW'(1));
            end
            if (dp_cmd.do_detach)
            begin
                if (det_found)
                begin
                    rsp_reg.ent <= slot_reg[det_pos[IW-1:0]];
                    rsp_reg.occupancy <= 5'(used_reg - CW'(1));
                end
                else
                    rsp_reg.status <= ST_NONE;
            end
        end
    end

    `include "assert_macros.svh"
    `ASSERT_CLK(a_used_bound, used_reg <= CW'(CAPACITY), "occupancy overflow")
    `ASSERT_CLK(a_scan_bound, scan_pos_reg <= used_reg, "scan past end")
    `ASSERT_CLK(a_age_keeps_count, dp_cmd.age_step |=> $stable(used_reg), "age changed count")
endmodule

[hw/rtl/priority_queue_with_aging.sv]
// priority_queue_with_aging: top level, controller plus datapath.
// Depends on pqa_pkg, pqa_if, pqa_ctrl, pqa_dp.
//
// Usage:
//  - req channel carries one command request (cmd, task fields, now).
//  - rsp channel returns one result per request: status, the entry taken
//    out (zero otherwise) and the occupancy after the command (5 bits).
//  - cfg channel writes aged_priority (index 0) or age_factor (index 1);
//    always ready, write only while no request is outstanding.
// Timing:
//  - One request at a time. Insert, detach, remove and unknown commands
//    have the result registered after one shift of the register file.
//    Age scans the N held entries and examines
//    one entry per cycle through a single elapsed/limit compare and a
//    16x4 multiply.
//  - A new request can be taken in the cycle after the previous result
//    was taken.
// Reset: queue empty, aged_priority 2, age_factor 6, no result pending.
// Stall: a result held by the receiver stays valid and stable; no new
//  request is accepted until it leaves.
module priority_queue_with_aging import pqa_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input logic clk,
    input logic rst_n,
    pqa_req_if.sink   req,
    pqa_rsp_if.source rsp,
    pqa_cfg_if.sink   cfg
);
    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;
    rsp_t     rsp_data;

    assign cfg.ready = 1'b1;

    pqa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req_cmd   (req.data.cmd),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat)
    );

    pqa_dp #(.CAPACITY(CAPACITY)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat),
        .req       (req.data),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_wdata (cfg.wdata),
        .rsp       (rsp_data)
    );

    assign rsp.data = rsp_data;
endmodule

[tb/pqa_checker.sv]
`timescale 1ns / 100ps
// pqa_checker: watches request, result and config channels of the aging queue,
// predicts each result and compares it. Depends on pqa_pkg and pqa_if.
module pqa_checker import pqa_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic clk,
    input  logic rst_n,
    pqa_req_if.monitor req,
    pqa_rsp_if.monitor rsp,
    pqa_cfg_if.monitor cfg,
    output int        errors,
    output int        pending
);
    entry_t   queue_q[$];
    logic [3:0] aged_pri;
    logic [3:0] factor;
    rsp_t     expected_q[$];

    function automatic rsp_t predict_cmd(req_t r);
        rsp_t o;
        int pos;
        int n;
        int k;
        entry_t e;
        logic [31:0] elapsed;
        logic [19:0] lim;
        o = '0;
        o.status = ST_DONE;
        if (r.cmd == CMD_SORTED || r.cmd == CMD_FRONT || r.cmd == CMD_BACK) begin
            if (queue_q.size() >= CAPACITY) o.status = ST_FULL;
            else begin
                if (r.cmd == CMD_FRONT) pos = 0;
                else if (r.cmd == CMD_BACK) pos = queue_q.size();
                else begin
                    pos = 0;
                    while (pos < queue_q.size() && queue_q[pos].pri < r.ent.pri) pos++;
                end
                queue_q.insert(pos, r.ent);
            end
        end else if (r.cmd == CMD_DETACH || r.cmd == CMD_REMOVE) begin
            pos = -1;
            if (r.cmd == CMD_REMOVE) pos = queue_q.size() - 1;
            else
                for (k = 0; k < queue_q.size(); k++)
                    if (pos < 0 && queue_q[k].id == r.ent.id) pos = k;
            if (pos < 0) o.status = ST_NONE;
            else begin
                o.ent = queue_q[pos];
                queue_q.delete(pos);
            end
        end else if (r.cmd == CMD_AGE) begin
            n = queue_q.size();
            pos = 0;
            // every entry held at the start is looked at once; moved ones go back
            for (k = 0; k < n; k++) begin
                e = queue_q[pos];
                elapsed = r.now - e.created;
                lim = 20'(e.quantum) * 20'(factor);
                if ({12'd0, elapsed} >= {24'd0, lim} && e.pri != aged_pri) begin
                    queue_q.delete(pos);
                    e.pri = aged_pri;
                    queue_q.push_back(e);
                end else pos++;
            end
        end
        o.occupancy = 5'(queue_q.size());
        return o;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        rsp_t w;
        if (!rst_n) begin
            queue_q.delete();
            expected_q.delete();
            aged_pri <= AGED_PRI_RST;
            factor   <= AGE_FACTOR_RST;
            errors   = 0;
            pending  = 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                if (cfg.index == CFG_AGED_PRI) aged_pri <= cfg.wdata;
                else factor <= cfg.wdata;
            end
            if (req.valid && req.ready) expected_q.push_back(predict_cmd(req.data));
            if (rsp.valid && rsp.ready) begin
                if (expected_q.size() == 0) report("unexpected result", rsp.data.status, '0);
                else begin
                    w = expected_q.pop_front();
                    if (rsp.data.status != w.status) report("status", rsp.data.status, w.status);
                    if (rsp.data.ent.id != w.ent.id) report("id", rsp.data.ent.id, w.ent.id);
                    if (rsp.data.ent.pri != w.ent.pri) report("priority", rsp.data.ent.pri, w.ent.pri);
                    if (rsp.data.ent.created != w.ent.created)
                        report("created", rsp.data.ent.created, w.ent.created);
                    if (rsp.data.ent.quantum != w.ent.quantum)
                        report("quantum", rsp.data.ent.quantum, w.ent.quantum);
                    if (rsp.data.occupancy != w.occupancy)
                        report("occupancy", rsp.data.occupancy, w.occupancy);
                end
            end
            pending = expected_q.size();
        end
    end
endmodule

[tb/priority_queue_with_aging_tb.sv]
`timescale 1ns / 100ps
// priority_queue_with_aging_tb: stimulus and verdict for the aging queue.
// Depends on pqa_pkg, pqa_if, pqa_checker and the block itself.
module priority_queue_with_aging_tb;
    import pqa_pkg::*;

    localparam int CAP = CAPACITY_DEF;
    localparam int LIMIT_CYCLES = 600000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pqa_req_if req ();
    pqa_rsp_if rsp ();
    pqa_cfg_if cfg ();

    int errors;
    int pending;
    int cycles = 0;
    int send_idle_pct = 0;   // chance in a hundred that the sender idles a cycle
    int recv_stall_pct = 0;  // chance in a hundred that the receiver stalls a cycle
    int hold_req = 0;        // bumped by the stimulus to ask for a long receiver stall
    int hold_done = 0;       // receiver's copy once the stall has run out
    int hold_cycles = 0;
    logic [15:0] live_ids[$]; // ids most recently inserted, for likely detach hits
    logic [31:0] clock_now = 32'h0000_1000;

    priority_queue_with_aging #(.CAPACITY(CAP)) DUT (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
    );

    pqa_checker #(.CAPACITY(CAP)) u_checker (
        .clk(clk), .rst_n(rst_n), .req(req.monitor), .rsp(rsp.monitor), .cfg(cfg.monitor),
        .errors(errors), .pending(pending)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // timeout watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("priority_queue_with_aging regression: fail");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold when asked
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (hold_done != hold_req)
        begin
            rsp.ready <= 1'b0;
            if (hold_cycles >= 300)
            begin
                hold_done <= hold_req;
                hold_cycles <= 0;
            end
            else
                hold_cycles <= hold_cycles + 1;
        end
        else
            rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // offer one request, wait for the handshake; valid stays up for a follow-on
    task automatic send_request(input logic [2:0] code, input entry_t e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.data.cmd <= code;
        req.data.ent <= e;
        req.data.now <= clock_now;
        req.valid <= 1'b1;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        @(negedge clk);
        if (code <= CMD_BACK)
            live_ids.push_back(e.id);
        if (live_ids.size() > 24)
            void'(live_ids.pop_front());
    endtask

    task automatic write_reg(input logic idx, input logic [3:0] val);
        cfg.index <= idx;
        cfg.wdata <= val;
        cfg.valid <= 1'b1;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
        @(negedge clk);
    endtask

    // wait until every result is back, then let an age scan finish
    task automatic drain();
        req.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (CAP + 8) @(negedge clk);
    endtask

    function automatic entry_t rand_entry();
        entry_t e;
        e.id = $urandom_range(7) == 0 ? 16'($urandom) : 16'($urandom_range(40));
        e.pri = 4'($urandom);
        // created trails the clock a little, sometimes wraps around
        e.created = $urandom_range(3) == 0 ? $urandom : clock_now - $urandom_range(3000);
        e.quantum = $urandom_range(5) == 0 ? 16'($urandom) : 16'($urandom_range(400));
        return e;
    endfunction

    task automatic random_request();
        entry_t e;
        int pick;
        e = rand_entry();
        pick = $urandom_range(99);
        clock_now = clock_now + $urandom_range(200);
        if ($urandom_range(30) == 0)
            clock_now = $urandom;
        if (pick < 45)
            send_request(pick < 25 ? CMD_SORTED : (pick < 35 ? CMD_FRONT : CMD_BACK), e);
        else if (pick < 65)
        begin
            if (live_ids.size() > 0 && $urandom_range(3) != 0)
                e.id = live_ids[$urandom_range(live_ids.size() - 1)];
            send_request(CMD_DETACH, e);
        end
        else if (pick < 80)
            send_request(CMD_REMOVE, e);
        else if (pick < 97)
            send_request(CMD_AGE, e);
        else
            send_request(3'($urandom_range(7, 6)), e);
    endtask

    initial
    begin
        entry_t e;
        int phase;
        req.valid = 1'b0;
        req.data = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_AGED_PRI;
        cfg.wdata = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty queue cases, extremes, fill to full, age corners
        send_request(CMD_REMOVE, '0);
        send_request(CMD_DETACH, '0);
        e = '{id: 16'hffff, pri: 4'hf, created: 32'hffff_ffff, quantum: 16'hffff};
        send_request(CMD_SORTED, e);
        e = '{id: 16'h0000, pri: 4'h0, created: 32'h0, quantum: 16'h0};
        send_request(CMD_FRONT, e);
        for (int k = 0; k < CAP; k++)
        begin
            e = '{id: 16'(k + 1), pri: 4'(k % 5), created: clock_now - 32'(k * 100),
                  quantum: 16'(k * 3)};
            send_request(k % 3 == 0 ? CMD_SORTED : (k % 3 == 1 ? CMD_BACK : CMD_FRONT), e);
        end
        clock_now = 32'h0000_0800;  // wraps against created times above
        send_request(CMD_AGE, e);
        send_request(CMD_DETACH, '{id: 16'h0007, pri: 4'h0, created: 32'h0, quantum: 16'h0});
        send_request(CMD_DETACH, '{id: 16'hffff, pri: 4'h0, created: 32'h0, quantum: 16'h0});
        send_request(3'd6, e);
        send_request(3'd7, e);
        send_request(CMD_REMOVE, e);
        drain();

        write_reg(CFG_AGED_PRI, 4'hf);
        write_reg(CFG_AGE_FACTOR, 4'h1);
        clock_now = 32'hffff_fff0;
        send_request(CMD_AGE, e);
        drain();

        // random phases with varying pressure and settings
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            write_reg(CFG_AGED_PRI, phase == 3 ? 4'h0 : 4'($urandom));
            write_reg(CFG_AGE_FACTOR, phase == 5 ? 4'hf : 4'($urandom_range(15, 1)));
            if (phase == 2)
                hold_req = hold_req + 1;
            repeat (225)
                random_request();
            // sender pauses until everything has come back
            drain();
        end

        drain();
        if (errors == 0)
            $display("priority_queue_with_aging regression: pass");
        else
            $display("priority_queue_with_aging regression: fail");
        $finish;
    end
endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/pqa_pkg.sv
hw/rtl/pqa_if.sv
hw/rtl/pqa_ctrl.sv
hw/rtl/pqa_dp.sv
hw/rtl/priority_queue_with_aging.sv
tb/pqa_checker.sv
tb/priority_queue_with_aging_tb.sv
